// File: hw/rtl/sbec_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the segment box entry clamp.
package sbec_pkg;

	localparam int CW         = 32;              // coordinate width, signed Q15.16
	localparam int FRAC_BITS  = 16;              // fraction bits of lambda
	localparam int FW         = FRAC_BITS + 1;   // lambda width, holds 1.0
	localparam int MAG_W      = 16;              // direction magnitude threshold width
	localparam int DIV_STAGES = FRAC_BITS + 1;   // integer step plus one step per fraction bit

	localparam logic [FW-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t origin_x;
		coord_t origin_y;
		coord_t origin_z;
		coord_t dir_x;
		coord_t dir_y;
		coord_t dir_z;
		coord_t box_min_x;
		coord_t box_min_y;
		coord_t box_min_z;
		coord_t box_max_x;
		coord_t box_max_y;
		coord_t box_max_z;
	} in_item_t;

	typedef struct packed {
		coord_t          point_x;
		coord_t          point_y;
		coord_t          point_z;
		logic [FW-1:0]   entry_fraction;
		logic            starts_inside;
	} out_item_t;

endpackage

// File: hw/rtl/sbec_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: unsigned lambda = num * 2^FRAC_BITS / den, one bit per stage.
module sbec_div (
	input  logic                            clk,
	input  logic [sbec_pkg::DIV_STAGES-1:0] en,
	input  logic [sbec_pkg::CW-1:0]         num,
	input  logic [sbec_pkg::CW-1:0]         den,
	output logic [sbec_pkg::FW-1:0]         quo,
	output logic                            ovf
);

	localparam int NS = sbec_pkg::DIV_STAGES;
	localparam int W  = sbec_pkg::CW;
	localparam int FB = sbec_pkg::FRAC_BITS;

	logic [W-1:0] rem_sd [NS];
	logic [W-1:0] den_sd [NS];
	logic [FB:0]  quo_sd [NS];
	logic         ovf_sd [NS];

	// integer step: num >= 2*den already puts lambda above 1
	always_ff @(posedge clk) begin
		if (en[0]) begin
			ovf_sd[0] <= {1'b0, num} >= {den, 1'b0};
			den_sd[0] <= den;
			if (num >= den) begin
				rem_sd[0] <= num - den;
				quo_sd[0] <= {{FB{1'b0}}, 1'b1};
			end else begin
				rem_sd[0] <= num;
				quo_sd[0] <= '0;
			end
		end
	end

	for (genvar k = 1; k < NS; k++) begin : g_step
		logic [W:0] trial;
		assign trial = {rem_sd[k-1], 1'b0};

		always_ff @(posedge clk) begin
			if (en[k]) begin
				den_sd[k] <= den_sd[k-1];
				ovf_sd[k] <= ovf_sd[k-1];
				if (trial >= {1'b0, den_sd[k-1]}) begin
					rem_sd[k] <= W'(trial - {1'b0, den_sd[k-1]});
					quo_sd[k] <= {quo_sd[k-1][FB-1:0], 1'b1};
				end else begin
					rem_sd[k] <= trial[W-1:0];
					quo_sd[k] <= {quo_sd[k-1][FB-1:0], 1'b0};
				end
			end
		end
	end

	assign quo = quo_sd[NS-1];
	assign ovf = ovf_sd[NS-1];

endmodule

// File: hw/rtl/segment_box_entry_clamp_unit.sv
`timescale 1ns / 1ps
// Top level of the segment box entry clamp: clips a segment start to an axis-aligned box.
//
// Input channel in_valid / in_stall / in_data carries one segment and one box per request.
// Output channel out_valid / out_stall / out_data returns one result per request, in order:
// the entry point on the box, its lambda (Q1.16, 1.0 = segment end) and the inside flag.
// cfg_valid / cfg_ready / cfg_data writes the minimum direction magnitude; cfg_ready is
// always high and the value should only change while no request is in flight.
//
// A new request can enter every cycle while in_stall is low. The depth is set by the six
// plane dividers, which retire one quotient bit per stage, followed by the hit-point
// multipliers, the minimum search and the final point multiply with saturation.
// Every stage carries a valid bit. When the receiver stalls, the result holds on out_data
// and the stages behind it keep filling empty slots, so in_stall rises only once every
// stage holds a request.
// Reset empties the pipeline and clears the threshold to zero; no clearing pass is needed.
module segment_box_entry_clamp_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [sbec_pkg::MAG_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  sbec_pkg::in_item_t           in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output sbec_pkg::out_item_t          out_data
);

	localparam int CW   = sbec_pkg::CW;
	localparam int FB   = sbec_pkg::FRAC_BITS;
	localparam int FW   = sbec_pkg::FW;
	localparam int PW   = CW + FW + 1;       // product of direction and lambda
	localparam int SW   = PW - FB;           // product scaled back to Q17.16
	localparam int CRW  = SW + 1;            // origin plus scaled step
	localparam int EXT  = CRW - CW;
	localparam logic [PW-1:0] BIAS = {{(PW-FB){1'b0}}, {FB{1'b1}}};

	// stage numbers
	localparam int S_DIV0 = 3;
	localparam int S_DIVN = S_DIV0 + sbec_pkg::DIV_STAGES - 1;
	localparam int S_M1   = S_DIVN + 1;
	localparam int S_M2   = S_M1 + 1;
	localparam int S_M3   = S_M2 + 1;
	localparam int S_M4   = S_M3 + 1;
	localparam int S_M5   = S_M4 + 1;
	localparam int S_M6   = S_M5 + 1;
	localparam int S_P1   = S_M6 + 1;
	localparam int S_P2   = S_P1 + 1;
	localparam int S_P3   = S_P2 + 1;
	localparam int L      = S_P3 + 1;

	// the two other axes of each axis
	localparam int OTH [3][2] = '{'{1, 2}, '{2, 0}, '{0, 1}};

	typedef struct packed {
		sbec_pkg::coord_t [2:0] org;
		sbec_pkg::coord_t [2:0] dir;
		sbec_pkg::coord_t [2:0] lo;
		sbec_pkg::coord_t [2:0] hi;
		logic                   org_in_box;
		logic [5:0]             plane_en;
		logic [5:0]             plane_agree;
	} carry_t;

	logic [sbec_pkg::MAG_W-1:0] min_mag_q;
	logic [L:1]   vld_s;
	logic [L:1]   en;
	logic [L-1:0] vld_feed;
	carry_t       carry_in;
	carry_t       carry_flags;
	carry_t       carry_s [1:L-1];

	logic [CW:0]    pdiff_s1 [6];
	logic [CW-1:0]  pmag_s2  [6];
	logic           pneg_s2  [6];
	logic [CW-1:0]  dmag_s2  [3];
	logic           dneg_s2  [3];
	logic [FW-1:0]  quo_d    [6];
	logic           ovf_d    [6];

	logic [FW-1:0]          q_sm1    [6];
	logic                   cand_sm1 [6];
	logic signed [PW-1:0]   prod_sm1 [6][2];
	logic [FW-1:0]          q_sm2    [6];
	logic                   cand_sm2 [6];
	logic [SW-1:0]          scl_sm2  [6][2];
	logic [FW-1:0]          q_sm3    [6];
	logic                   cand_sm3 [6];
	logic [CRW-1:0]         crd_sm3  [6][2];
	logic [FW-1:0]          v_sm4    [6];
	logic [FW-1:0]          amin_sm5 [3];
	logic [FW-1:0]          best_sm6;
	logic signed [PW-1:0]   prod_sp1 [3];
	logic [FW-1:0]          best_sp1;
	logic [SW-1:0]          scl_sp2  [3];
	logic [FW-1:0]          best_sp2;
	logic [CRW-1:0]         sum_sp3  [3];
	logic [FW-1:0]          best_sp3;
	sbec_pkg::out_item_t    out_sp4;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_mag_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			min_mag_q <= cfg_data;
		end
	end

	// a stage may load when it is empty or some stage ahead of it can move
	for (genvar i = 1; i <= L; i++) begin : g_en
		assign en[i] = !out_stall || !(&vld_s[L:i]);
	end

	assign vld_feed = {vld_s[L-1:1], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int i = 1; i <= L; i++) begin
				if (en[i]) begin
					vld_s[i] <= vld_feed[i-1];
				end
			end
		end
	end

	assign in_stall  = !en[1];
	assign out_valid = vld_s[L];
	assign out_data  = out_sp4;

	// request fields in axis order, inside test on the raw origin
	always_comb begin
		carry_in             = '0;
		carry_in.org         = {in_data.origin_z, in_data.origin_y, in_data.origin_x};
		carry_in.dir         = {in_data.dir_z, in_data.dir_y, in_data.dir_x};
		carry_in.lo          = {in_data.box_min_z, in_data.box_min_y, in_data.box_min_x};
		carry_in.hi          = {in_data.box_max_z, in_data.box_max_y, in_data.box_max_x};
		carry_in.org_in_box  = 1'b1;
		for (int a = 0; a < 3; a++) begin
			if ($signed(carry_in.org[a]) < $signed(carry_in.lo[a]) ||
			    $signed(carry_in.org[a]) > $signed(carry_in.hi[a])) begin
				carry_in.org_in_box = 1'b0;
			end
		end
	end

	// plane enables and sign agreement, joined to the request at the first divider stage
	always_comb begin
		carry_flags = carry_s[2];
		for (int a = 0; a < 3; a++) begin
			for (int k = 0; k < 2; k++) begin
				carry_flags.plane_en[2*a+k]    = dmag_s2[a] > {{(CW-sbec_pkg::MAG_W){1'b0}}, min_mag_q};
				carry_flags.plane_agree[2*a+k] = pneg_s2[2*a+k] == dneg_s2[a];
			end
		end
	end

	for (genvar i = 1; i < L; i++) begin : g_carry
		carry_t nxt;
		if (i == 1) begin : g_first
			assign nxt = carry_in;
		end else if (i == S_DIV0) begin : g_flags
			assign nxt = carry_flags;
		end else begin : g_pass
			assign nxt = carry_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (en[i]) begin
				carry_s[i] <= nxt;
			end
		end
	end

	// s1: plane minus origin, 33 bits
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int a = 0; a < 3; a++) begin
				pdiff_s1[2*a]   <= {carry_in.lo[a][CW-1], carry_in.lo[a]} -
				                   {carry_in.org[a][CW-1], carry_in.org[a]};
				pdiff_s1[2*a+1] <= {carry_in.hi[a][CW-1], carry_in.hi[a]} -
				                   {carry_in.org[a][CW-1], carry_in.org[a]};
			end
		end
	end

	// s2: magnitudes and signs
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int j = 0; j < 6; j++) begin
				pneg_s2[j] <= pdiff_s1[j][CW];
				pmag_s2[j] <= pdiff_s1[j][CW] ? CW'(-pdiff_s1[j]) : pdiff_s1[j][CW-1:0];
			end
			for (int a = 0; a < 3; a++) begin
				dneg_s2[a] <= carry_s[1].dir[a][CW-1];
				dmag_s2[a] <= carry_s[1].dir[a][CW-1] ? -carry_s[1].dir[a] : carry_s[1].dir[a];
			end
		end
	end

	// plane dividers
	for (genvar j = 0; j < 6; j++) begin : g_div
		sbec_div u_div (
			.clk (clk),
			.en  (en[S_DIVN:S_DIV0]),
			.num (pmag_s2[j]),
			.den (dmag_s2[j/2]),
			.quo (quo_d[j]),
			.ovf (ovf_d[j])
		);
	end

	// m1: candidate check and products of the other axes' directions with lambda
	always_ff @(posedge clk) begin
		if (en[S_M1]) begin
			for (int a = 0; a < 3; a++) begin
				for (int k = 0; k < 2; k++) begin
					q_sm1[2*a+k]    <= quo_d[2*a+k];
					// negative lambda only when signs differ and the quotient is nonzero
					cand_sm1[2*a+k] <= carry_s[S_DIVN].plane_en[2*a+k] && !ovf_d[2*a+k] &&
					                   (quo_d[2*a+k] <= sbec_pkg::FRAC_ONE) &&
					                   (quo_d[2*a+k] == '0 ||
					                    carry_s[S_DIVN].plane_agree[2*a+k]);
					for (int m = 0; m < 2; m++) begin
						prod_sm1[2*a+k][m] <= $signed(carry_s[S_DIVN].dir[OTH[a][m]]) *
						                      $signed({1'b0, quo_d[2*a+k]});
					end
				end
			end
		end
	end

	// m2: scale back, truncating toward zero
	always_ff @(posedge clk) begin
		if (en[S_M2]) begin
			for (int j = 0; j < 6; j++) begin
				q_sm2[j]    <= q_sm1[j];
				cand_sm2[j] <= cand_sm1[j];
				for (int m = 0; m < 2; m++) begin
					scl_sm2[j][m] <= SW'((prod_sm1[j][m] +
					                 (prod_sm1[j][m][PW-1] ? BIAS : '0)) >> FB);
				end
			end
		end
	end

	// m3: hit coordinates on the other axes
	always_ff @(posedge clk) begin
		if (en[S_M3]) begin
			for (int a = 0; a < 3; a++) begin
				for (int k = 0; k < 2; k++) begin
					q_sm3[2*a+k]    <= q_sm2[2*a+k];
					cand_sm3[2*a+k] <= cand_sm2[2*a+k];
					for (int m = 0; m < 2; m++) begin
						crd_sm3[2*a+k][m] <=
							{{EXT{carry_s[S_M2].org[OTH[a][m]][CW-1]}},
							 carry_s[S_M2].org[OTH[a][m]]} +
							{scl_sm2[2*a+k][m][SW-1], scl_sm2[2*a+k][m]};
					end
				end
			end
		end
	end

	// m4: box test of the hit point; a miss reads as the segment end
	always_ff @(posedge clk) begin
		if (en[S_M4]) begin
			for (int a = 0; a < 3; a++) begin
				for (int k = 0; k < 2; k++) begin
					logic hit;
					hit = cand_sm3[2*a+k];
					for (int m = 0; m < 2; m++) begin
						if ($signed(crd_sm3[2*a+k][m]) <
						    $signed({{EXT{carry_s[S_M3].lo[OTH[a][m]][CW-1]}},
						             carry_s[S_M3].lo[OTH[a][m]]}) ||
						    $signed(crd_sm3[2*a+k][m]) >
						    $signed({{EXT{carry_s[S_M3].hi[OTH[a][m]][CW-1]}},
						             carry_s[S_M3].hi[OTH[a][m]]})) begin
							hit = 1'b0;
						end
					end
					v_sm4[2*a+k] <= hit ? q_sm3[2*a+k] : sbec_pkg::FRAC_ONE;
				end
			end
		end
	end

	// m5, m6: minimum over the six planes
	always_ff @(posedge clk) begin
		if (en[S_M5]) begin
			for (int a = 0; a < 3; a++) begin
				amin_sm5[a] <= (v_sm4[2*a] < v_sm4[2*a+1]) ? v_sm4[2*a] : v_sm4[2*a+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[S_M6]) begin
			logic [FW-1:0] m01;
			m01 = (amin_sm5[0] < amin_sm5[1]) ? amin_sm5[0] : amin_sm5[1];
			best_sm6 <= (m01 < amin_sm5[2]) ? m01 : amin_sm5[2];
		end
	end

	// p1..p3: point at the chosen lambda
	always_ff @(posedge clk) begin
		if (en[S_P1]) begin
			best_sp1 <= best_sm6;
			for (int a = 0; a < 3; a++) begin
				prod_sp1[a] <= $signed(carry_s[S_M6].dir[a]) * $signed({1'b0, best_sm6});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[S_P2]) begin
			best_sp2 <= best_sp1;
			for (int a = 0; a < 3; a++) begin
				scl_sp2[a] <= SW'((prod_sp1[a] + (prod_sp1[a][PW-1] ? BIAS : '0)) >> FB);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[S_P3]) begin
			best_sp3 <= best_sp2;
			for (int a = 0; a < 3; a++) begin
				sum_sp3[a] <= {{EXT{carry_s[S_P2].org[a][CW-1]}}, carry_s[S_P2].org[a]} +
				              {scl_sp2[a][SW-1], scl_sp2[a]};
			end
		end
	end

	// p4: saturate, inside override, output register
	always_ff @(posedge clk) begin
		if (en[L]) begin
			logic [CW-1:0] pt [3];
			for (int a = 0; a < 3; a++) begin
				if ((&sum_sp3[a][CRW-1:CW-1]) || !(|sum_sp3[a][CRW-1:CW-1])) begin
					pt[a] = sum_sp3[a][CW-1:0];
				end else if (sum_sp3[a][CRW-1]) begin
					pt[a] = {1'b1, {(CW-1){1'b0}}};
				end else begin
					pt[a] = {1'b0, {(CW-1){1'b1}}};
				end
			end
			if (carry_s[S_P3].org_in_box) begin
				out_sp4.point_x        <= carry_s[S_P3].org[0];
				out_sp4.point_y        <= carry_s[S_P3].org[1];
				out_sp4.point_z        <= carry_s[S_P3].org[2];
				out_sp4.entry_fraction <= '0;
				out_sp4.starts_inside  <= 1'b1;
			end else begin
				out_sp4.point_x        <= pt[0];
				out_sp4.point_y        <= pt[1];
				out_sp4.point_z        <= pt[2];
				out_sp4.entry_fraction <= best_sp3;
				out_sp4.starts_inside  <= 1'b0;
			end
		end
	end

	// input backs up only when every stage is occupied and the output is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> ((&vld_s) && out_stall))
		else $error("input stalled with an empty stage in the pipeline");

	// a request taken without a result leaving adds exactly one occupied stage
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !(out_valid && !out_stall)) |=>
		($countones(vld_s) == $past($countones(vld_s)) + 1))
		else $error("request lost or duplicated in the pipeline");

	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.entry_fraction <= sbec_pkg::FRAC_ONE) &&
		               (!out_data.starts_inside || out_data.entry_fraction == '0)))
		else $error("entry fraction out of range");

endmodule
